FILE: rtl/gar_pkg.sv
// shared types, codes and helpers for the gamepad action repeater
package gar_pkg;

  localparam int KEY_BITS   = 17;
  localparam int AXIS_W     = 16;
  localparam int MAG_W      = 15;
  localparam int TIME_W     = 32;
  localparam int MS_W       = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int BTN_N      = 8;
  localparam int BTN_IDX_W  = 3;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = 1;
  localparam int FIFO_CNT_W = 2;

  localparam logic [CFG_ADDR_W-1:0] CFG_DEADZONE  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_NEUTRAL   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_INIT_DLY  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_REP_INTVL = 2'd3;

  localparam logic [MAG_W-1:0] DEADZONE_RST  = 15'd18000;
  localparam logic [MAG_W-1:0] NEUTRAL_RST   = 15'd9830;
  localparam logic [MS_W-1:0]  INIT_DLY_RST  = 16'd400;
  localparam logic [MS_W-1:0]  REP_INTVL_RST = 16'd100;

  localparam logic [AXIS_W-1:0] AXIS_BAD = 16'h8000;

  localparam logic [3:0] ACT_NONE     = 4'd0;
  localparam logic [3:0] ACT_ACCEPT   = 4'd1;
  localparam logic [3:0] ACT_BACK     = 4'd2;
  localparam logic [3:0] ACT_FAVORITE = 4'd3;
  localparam logic [3:0] ACT_ERASE    = 4'd4;
  localparam logic [3:0] ACT_SUBMIT   = 4'd5;
  localparam logic [3:0] ACT_QUICK    = 4'd6;
  localparam logic [3:0] ACT_PREVTAB  = 4'd7;
  localparam logic [3:0] ACT_NEXTTAB  = 4'd8;
  localparam logic [3:0] ACT_LEFT     = 4'd9;
  localparam logic [3:0] ACT_RIGHT    = 4'd10;
  localparam logic [3:0] ACT_UP       = 4'd11;
  localparam logic [3:0] ACT_DOWN     = 4'd12;

  localparam logic [2:0] DIR_NONE  = 3'd0;
  localparam logic [2:0] DIR_LEFT  = 3'd1;
  localparam logic [2:0] DIR_RIGHT = 3'd2;
  localparam logic [2:0] DIR_UP    = 3'd3;
  localparam logic [2:0] DIR_DOWN  = 3'd4;

  typedef struct packed {
    logic [BTN_N-1:0] btn;
    logic             dir_vld;
    logic [3:0]       dir_code;
    logic             dir_rep;
    logic             chg;
    logic             rej;
  } plan_t;

  // button slots: key bits 0..5, then back (8) and start (9)
  function automatic logic [3:0] btn_code(input logic [BTN_IDX_W-1:0] idx);
    logic [3:0] c;
    unique case (idx)
      3'd0: c = ACT_BACK;
      3'd1: c = ACT_ACCEPT;
      3'd2: c = ACT_FAVORITE;
      3'd3: c = ACT_ERASE;
      3'd4: c = ACT_PREVTAB;
      3'd5: c = ACT_NEXTTAB;
      3'd6: c = ACT_QUICK;
      3'd7: c = ACT_SUBMIT;
      default: c = ACT_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] dir_action(input logic [2:0] dir);
    logic [3:0] c;
    unique case (dir)
      DIR_LEFT:  c = ACT_LEFT;
      DIR_RIGHT: c = ACT_RIGHT;
      DIR_UP:    c = ACT_UP;
      DIR_DOWN:  c = ACT_DOWN;
      default:   c = ACT_NONE;
    endcase
    return c;
  endfunction

  function automatic logic [MAG_W-1:0] axis_mag(input logic signed [AXIS_W-1:0] v);
    logic [AXIS_W-1:0] a;
    a = v[AXIS_W-1] ? (~v + 1'b1) : v;
    return a[MAG_W-1:0];
  endfunction

  function automatic logic [BTN_IDX_W-1:0] low_idx(input logic [BTN_N-1:0] m);
    logic [BTN_IDX_W-1:0] r;
    r = '0;
    for (int i = BTN_N - 1; i >= 0; i--) begin
      if (m[i]) r = BTN_IDX_W'(i);
    end
    return r;
  endfunction

endpackage

FILE: rtl/gar_front.sv
// front end: config registers, sample classification and pad state
module gar_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [gar_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [gar_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                 accept,
  input  logic                                 in_func,
  input  logic [gar_pkg::KEY_BITS-1:0]         in_keys,
  input  logic signed [gar_pkg::AXIS_W-1:0]    in_stick_left_x,
  input  logic signed [gar_pkg::AXIS_W-1:0]    in_stick_left_y,
  input  logic signed [gar_pkg::AXIS_W-1:0]    in_stick_right_x,
  input  logic signed [gar_pkg::AXIS_W-1:0]    in_stick_right_y,
  input  logic [gar_pkg::TIME_W-1:0]           in_now_ms,
  output logic                                 plan_push,
  output gar_pkg::plan_t                       plan
);
  import gar_pkg::*;

  logic [MAG_W-1:0]    deadzone_r, neutral_r;
  logic [MS_W-1:0]     init_dly_r, rep_intvl_r;

  logic [KEY_BITS-1:0] prev_keys_r;
  logic [15:0]         rep_keys_r;
  logic [AXIS_W-1:0]   rep_ax_r [4];
  logic                has_rep_r, waiting_r, repeating_r;
  logic [2:0]          held_r;
  logic [TIME_W-1:0]   start_r;

  logic [AXIS_W-1:0]   ax [4];
  logic                rej, chg, neutral, dir_change, dir_rep_fire;
  logic [KEY_BITS-1:0] pressed;
  logic [MAG_W-1:0]    mx, my;
  logic [2:0]          stick_dir, held;
  logic [TIME_W-1:0]   elapsed, limit;

  always_comb begin
    ax[0] = in_stick_left_x;
    ax[1] = in_stick_left_y;
    ax[2] = in_stick_right_x;
    ax[3] = in_stick_right_y;
    rej = 1'b0;
    chg = !has_rep_r || (rep_keys_r != in_keys[15:0]);
    neutral = (in_keys == '0);
    for (int i = 0; i < 4; i++) begin
      if (ax[i] == AXIS_BAD) rej = 1'b1;
      if (ax[i] != rep_ax_r[i]) chg = 1'b1;
      if (axis_mag(ax[i]) >= neutral_r) neutral = 1'b0;
    end
    pressed = in_keys & ~prev_keys_r;

    mx = axis_mag(in_stick_left_x);
    my = axis_mag(in_stick_left_y);
    if (mx < deadzone_r && my < deadzone_r) stick_dir = DIR_NONE;
    else if (mx > my) stick_dir = in_stick_left_x[AXIS_W-1] ? DIR_LEFT : DIR_RIGHT;
    else stick_dir = in_stick_left_y[AXIS_W-1] ? DIR_UP : DIR_DOWN;

    priority if (in_keys[12]) held = DIR_LEFT;
    else if (in_keys[13]) held = DIR_RIGHT;
    else if (in_keys[10]) held = DIR_UP;
    else if (in_keys[11]) held = DIR_DOWN;
    else held = stick_dir;

    elapsed = in_now_ms - start_r;
    limit = repeating_r ? TIME_W'(rep_intvl_r) : TIME_W'(init_dly_r);
    dir_change = !waiting_r && (held != held_r);
    dir_rep_fire = !waiting_r && (held == held_r) && (held != DIR_NONE) &&
                   (elapsed >= limit);

    plan.rej      = rej;
    plan.chg      = rej ? 1'b0 : chg;
    plan.btn      = (rej || waiting_r) ? '0 : {pressed[9:8], pressed[5:0]};
    plan.dir_vld  = !rej && ((dir_change && held != DIR_NONE) || dir_rep_fire);
    plan.dir_code = dir_action(held);
    plan.dir_rep  = dir_rep_fire;
    plan_push     = accept && !in_func;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadzone_r  <= DEADZONE_RST;
      neutral_r   <= NEUTRAL_RST;
      init_dly_r  <= INIT_DLY_RST;
      rep_intvl_r <= REP_INTVL_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_DEADZONE:  deadzone_r  <= cfg_wdata[MAG_W-1:0];
        CFG_NEUTRAL:   neutral_r   <= cfg_wdata[MAG_W-1:0];
        CFG_INIT_DLY:  init_dly_r  <= cfg_wdata;
        CFG_REP_INTVL: rep_intvl_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_keys_r <= '0;
      rep_keys_r  <= '0;
      for (int i = 0; i < 4; i++) rep_ax_r[i] <= '0;
      has_rep_r   <= 1'b0;
      waiting_r   <= 1'b0;
      repeating_r <= 1'b0;
      held_r      <= DIR_NONE;
      start_r     <= '0;
    end else if (accept) begin
      if (in_func) begin
        waiting_r   <= 1'b1;
        held_r      <= DIR_NONE;
        repeating_r <= 1'b0;
      end else if (!rej) begin
        prev_keys_r <= in_keys;
        if (chg) begin
          has_rep_r  <= 1'b1;
          rep_keys_r <= in_keys[15:0];
          for (int i = 0; i < 4; i++) rep_ax_r[i] <= ax[i];
        end
        if (waiting_r) begin
          if (neutral) waiting_r <= 1'b0;
        end else if (dir_change) begin
          held_r      <= held;
          repeating_r <= 1'b0;
          start_r     <= in_now_ms;
        end else if (dir_rep_fire) begin
          repeating_r <= 1'b1;
          start_r     <= in_now_ms;
        end
      end
    end
  end

endmodule

FILE: rtl/gar_fifo.sv
// short plan queue between front and back end
module gar_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  gar_pkg::plan_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           vld,
  output gar_pkg::plan_t rdata
);
  import gar_pkg::*;

  plan_t                 mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r;

  assign full  = (cnt_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign vld   = (cnt_r != '0);
  assign rdata = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

FILE: rtl/gar_back.sv
// back end: unrolls one plan into result words, one per cycle while the output is popped
module gar_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           plan_vld,
  input  gar_pkg::plan_t plan,
  output logic           plan_pop,
  input  logic           pop,
  output logic           empty,
  output logic [3:0]     out_action_code,
  output logic           out_is_repeat,
  output logic           out_state_changed,
  output logic           out_rejected,
  output logic           out_last
);
  import gar_pkg::*;

  plan_t      cur_r, cur_nxt;
  logic       cur_vld_r;
  logic       out_vld_r;
  logic [3:0] code;
  logic       rep, last, emit;
  logic [BTN_N-1:0] btn_rest;

  always_comb begin
    btn_rest = cur_r.btn & (cur_r.btn - 1'b1);
    cur_nxt  = cur_r;
    if (cur_r.btn != '0) begin
      code = btn_code(low_idx(cur_r.btn));
      rep  = 1'b0;
      last = (btn_rest == '0) && !cur_r.dir_vld;
      cur_nxt.btn = btn_rest;
    end else if (cur_r.dir_vld) begin
      code = cur_r.dir_code;
      rep  = cur_r.dir_rep;
      last = 1'b1;
      cur_nxt.dir_vld = 1'b0;
    end else begin
      code = ACT_NONE;
      rep  = 1'b0;
      last = 1'b1;
    end
    emit     = cur_vld_r && (!out_vld_r || pop);
    plan_pop = plan_vld && (!cur_vld_r || (emit && last));
  end

  assign empty = !out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (plan_pop) cur_vld_r <= 1'b1;
      else if (emit && last) cur_vld_r <= 1'b0;
      if (emit) out_vld_r <= 1'b1;
      else if (pop) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (plan_pop) cur_r <= plan;
    else if (emit) cur_r <= cur_nxt;
    if (emit) begin
      out_action_code   <= code;
      out_is_repeat     <= rep;
      out_state_changed <= cur_r.chg;
      out_rejected      <= cur_r.rej;
      out_last          <= last;
    end
  end

endmodule

FILE: rtl/gamepad_action_repeater_core.sv
// Gamepad action repeater: takes polled pad samples (or a suppress command) and
// emits action words with typematic repeat of the held direction. The front end
// accepts one sample per cycle while its two-entry plan queue has room; sample
// state updates in that cycle. The back end writes one result word per cycle
// while its output is taken; a sample gives max(1, newly pressed mapped buttons +
// one direction event if any) words, at most 9; that serializer sets the sustained
// rate; suppress gives no word. Config is written only while idle, user-enforced.
module gamepad_action_repeater_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [gar_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [gar_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              push,
  output logic                              full,
  input  logic                              in_func,
  input  logic [gar_pkg::KEY_BITS-1:0]      in_keys,
  input  logic signed [gar_pkg::AXIS_W-1:0] in_stick_left_x,
  input  logic signed [gar_pkg::AXIS_W-1:0] in_stick_left_y,
  input  logic signed [gar_pkg::AXIS_W-1:0] in_stick_right_x,
  input  logic signed [gar_pkg::AXIS_W-1:0] in_stick_right_y,
  input  logic [gar_pkg::TIME_W-1:0]        in_now_ms,
  output logic                              empty,
  input  logic                              pop,
  output logic [3:0]                        out_action_code,
  output logic                              out_is_repeat,
  output logic                              out_state_changed,
  output logic                              out_rejected,
  output logic                              out_last
);
  import gar_pkg::*;

  logic  accept, plan_push, plan_pop, plan_vld;
  plan_t plan_in, plan_head;

  assign accept = push && !full;

  gar_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_wdata,
    .accept, .in_func, .in_keys,
    .in_stick_left_x, .in_stick_left_y, .in_stick_right_x, .in_stick_right_y,
    .in_now_ms, .plan_push, .plan(plan_in)
  );

  gar_fifo u_fifo (
    .clk, .rst_n, .push(plan_push), .wdata(plan_in), .full,
    .pop(plan_pop), .vld(plan_vld), .rdata(plan_head)
  );

  gar_back u_back (
    .clk, .rst_n, .plan_vld, .plan(plan_head), .plan_pop, .pop, .empty,
    .out_action_code, .out_is_repeat, .out_state_changed, .out_rejected, .out_last
  );

  a_rej_word: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_rejected) |-> (out_last && out_action_code == ACT_NONE &&
                                  !out_state_changed && !out_is_repeat))
    else $error("rejected word malformed");

  a_rep_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_is_repeat) |-> (out_action_code >= ACT_LEFT &&
                                   out_action_code <= ACT_DOWN))
    else $error("repeat on non-direction action");

  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_action_code == ACT_NONE) |-> out_last)
    else $error("empty action not last");

  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    (plan_pop |-> plan_vld) and (plan_push |-> !full))
    else $error("plan queue misuse");

endmodule

FILE: test/tb_gamepad_action_repeater_core.sv
// testbench for the gamepad action repeater core: directed and random samples checked per word
`timescale 1ns / 100ps

module tb_gamepad_action_repeater_core;
  import gar_pkg::*;

  localparam logic FUNC_SAMPLE   = 1'b0;
  localparam logic FUNC_SUPPRESS = 1'b1;

  localparam int KEY_B          = 0;
  localparam int KEY_A          = 1;
  localparam int KEY_X          = 2;
  localparam int KEY_Y          = 3;
  localparam int KEY_LB         = 4;
  localparam int KEY_RB         = 5;
  localparam int KEY_BACK       = 8;
  localparam int KEY_START      = 9;
  localparam int KEY_DPAD_UP    = 10;
  localparam int KEY_DPAD_DOWN  = 11;
  localparam int KEY_DPAD_LEFT  = 12;
  localparam int KEY_DPAD_RIGHT = 13;

  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic                     func;
    logic [KEY_BITS-1:0]      keys;
    logic [3:0][AXIS_W-1:0]   axis;
    logic [TIME_W-1:0]        now;
  } pad_sample_t;

  typedef struct packed {
    logic [3:0] code;
    logic       rep;
    logic       chg;
    logic       rej;
    logic       last;
  } pad_word_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]    cfg_addr = '0;
  logic [CFG_DATA_W-1:0]    cfg_wdata = '0;
  logic                     push = 1'b0;
  logic                     full;
  logic                     in_func = 1'b0;
  logic [KEY_BITS-1:0]      in_keys = '0;
  logic signed [AXIS_W-1:0] in_stick_left_x = '0;
  logic signed [AXIS_W-1:0] in_stick_left_y = '0;
  logic signed [AXIS_W-1:0] in_stick_right_x = '0;
  logic signed [AXIS_W-1:0] in_stick_right_y = '0;
  logic [TIME_W-1:0]        in_now_ms = '0;
  logic                     empty;
  logic                     pop = 1'b0;
  logic [3:0]               out_action_code;
  logic                     out_is_repeat;
  logic                     out_state_changed;
  logic                     out_rejected;
  logic                     out_last;

  // predictor copy of configuration and state
  logic [MAG_W-1:0]         dead_zone = DEADZONE_RST;
  logic [MAG_W-1:0]         neutral_thr = NEUTRAL_RST;
  logic [MS_W-1:0]          init_delay = INIT_DLY_RST;
  logic [MS_W-1:0]          rep_interval = REP_INTVL_RST;
  logic [KEY_BITS-1:0]      prev_keys = '0;
  logic [15:0]              rep_keys = '0;
  logic [3:0][AXIS_W-1:0]   rep_axes = '0;
  logic                     has_rep = 1'b0;
  logic                     wait_neutral = 1'b0;
  logic [2:0]               held_dir = DIR_NONE;
  logic                     repeating = 1'b0;
  logic [TIME_W-1:0]        rep_start = '0;

  // random pad that evolves between samples
  logic [KEY_BITS-1:0]      pad_keys = '0;
  logic [3:0][AXIS_W-1:0]   pad_axis = '0;
  logic [TIME_W-1:0]        pad_clock = '0;

  pad_word_t expected_words [$];
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int idle_cycles = 0;

  gamepad_action_repeater_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .push             (push),
    .full             (full),
    .in_func          (in_func),
    .in_keys          (in_keys),
    .in_stick_left_x  (in_stick_left_x),
    .in_stick_left_y  (in_stick_left_y),
    .in_stick_right_x (in_stick_right_x),
    .in_stick_right_y (in_stick_right_y),
    .in_now_ms        (in_now_ms),
    .empty            (empty),
    .pop              (pop),
    .out_action_code  (out_action_code),
    .out_is_repeat    (out_is_repeat),
    .out_state_changed(out_state_changed),
    .out_rejected     (out_rejected),
    .out_last         (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic pad_word_t make_word(input logic [3:0] code, input logic rep,
                                          input logic chg, input logic rej);
    pad_word_t w;
    w.code = code;
    w.rep  = rep;
    w.chg  = chg;
    w.rej  = rej;
    w.last = 1'b0;
    return w;
  endfunction

  function automatic logic [3:0] key_action(input int b);
    case (b)
      KEY_B:     return ACT_BACK;
      KEY_A:     return ACT_ACCEPT;
      KEY_X:     return ACT_FAVORITE;
      KEY_Y:     return ACT_ERASE;
      KEY_LB:    return ACT_PREVTAB;
      KEY_RB:    return ACT_NEXTTAB;
      KEY_BACK:  return ACT_QUICK;
      KEY_START: return ACT_SUBMIT;
      default:   return ACT_NONE;
    endcase
  endfunction

  function automatic int axis_size(input int v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [2:0] stick_dir(input int x, input int y);
    int mx;
    int my;
    mx = axis_size(x);
    my = axis_size(y);
    if (mx < int'(dead_zone) && my < int'(dead_zone)) return DIR_NONE;
    if (mx > my) return x < 0 ? DIR_LEFT : DIR_RIGHT;
    return y < 0 ? DIR_UP : DIR_DOWN;
  endfunction

  task automatic predict_words(input pad_sample_t s);
    pad_word_t words [10];
    int ax [4];
    int n;
    logic [KEY_BITS-1:0] pressed;
    logic chg;
    logic neutral;
    logic [2:0] held;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] lim;
    if (s.func == FUNC_SUPPRESS) begin
      wait_neutral = 1'b1;
      held_dir = DIR_NONE;
      repeating = 1'b0;
      return;
    end
    for (int i = 0; i < 4; i++) begin
      if (s.axis[i] == AXIS_BAD) begin
        words[0] = make_word(ACT_NONE, 1'b0, 1'b0, 1'b1);
        words[0].last = 1'b1;
        expected_words.push_back(words[0]);
        return;
      end
      ax[i] = int'($signed(s.axis[i]));
    end

    pressed = s.keys & ~prev_keys;
    prev_keys = s.keys;
    chg = !has_rep || rep_keys != s.keys[15:0] || rep_axes != s.axis;
    if (chg) begin
      has_rep = 1'b1;
      rep_keys = s.keys[15:0];
      rep_axes = s.axis;
    end

    n = 0;
    if (!wait_neutral) begin
      for (int b = 0; b < KEY_BITS; b++) begin
        if (pressed[b] && key_action(b) != ACT_NONE) begin
          words[n] = make_word(key_action(b), 1'b0, chg, 1'b0);
          n++;
        end
      end
    end

    if (s.keys[KEY_DPAD_LEFT]) held = DIR_LEFT;
    else if (s.keys[KEY_DPAD_RIGHT]) held = DIR_RIGHT;
    else if (s.keys[KEY_DPAD_UP]) held = DIR_UP;
    else if (s.keys[KEY_DPAD_DOWN]) held = DIR_DOWN;
    else held = stick_dir(ax[0], ax[1]);

    neutral = (s.keys == '0);
    for (int i = 0; i < 4; i++) begin
      if (axis_size(ax[i]) >= int'(neutral_thr)) neutral = 1'b0;
    end

    elapsed = s.now - rep_start;
    lim = repeating ? TIME_W'(rep_interval) : TIME_W'(init_delay);
    if (wait_neutral) begin
      if (neutral) wait_neutral = 1'b0;
    end else if (held != held_dir) begin
      held_dir = held;
      repeating = 1'b0;
      rep_start = s.now;
      if (held != DIR_NONE) begin
        words[n] = make_word(4'(ACT_LEFT + held - DIR_LEFT), 1'b0, chg, 1'b0);
        n++;
      end
    end else if (held != DIR_NONE && elapsed >= lim) begin
      repeating = 1'b1;
      rep_start = s.now;
      words[n] = make_word(4'(ACT_LEFT + held - DIR_LEFT), 1'b1, chg, 1'b0);
      n++;
    end

    if (n == 0) begin
      words[0] = make_word(ACT_NONE, 1'b0, chg, 1'b0);
      n = 1;
    end
    words[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_words.push_back(words[i]);
  endtask

  function automatic pad_sample_t pad_sample(input logic [KEY_BITS-1:0] keys, input int lx,
                                             input int ly, input int rx, input int ry,
                                             input logic [TIME_W-1:0] now);
    pad_sample_t s;
    s.func = FUNC_SAMPLE;
    s.keys = keys;
    s.axis = {16'(ry), 16'(rx), 16'(ly), 16'(lx)};
    s.now  = now;
    return s;
  endfunction

  function automatic pad_sample_t random_sample();
    pad_sample_t s;
    int r;
    int idx;
    r = $urandom_range(99);
    if (r < 4) begin
      s.func = FUNC_SUPPRESS;
      s.keys = 17'($urandom);
      s.axis = {$urandom, $urandom};
      s.now  = $urandom;
      return s;
    end
    case ($urandom_range(7))
      0: pad_keys = 17'($urandom);
      1: pad_keys = '0;
      default: begin
        idx = $urandom_range(KEY_BITS - 1);
        if ($urandom_range(1)) pad_keys[idx] = ~pad_keys[idx];
      end
    endcase
    for (int i = 0; i < 4; i++) begin
      case ($urandom_range(9))
        0, 1: pad_axis[i] = 16'($urandom);
        2: pad_axis[i] = '0;
        3: pad_axis[i] = 16'($urandom_range(0, 2000)) - 16'd1000;
        4: pad_axis[i] = $urandom_range(1) ? 16'h7fff : 16'h8001;
        default: ;
      endcase
    end
    case ($urandom_range(19))
      0: pad_clock = $urandom;
      1, 2: pad_clock = pad_clock + $urandom_range(0, 1000);
      default: pad_clock = pad_clock + 32'd16;
    endcase
    s.func = FUNC_SAMPLE;
    s.keys = pad_keys;
    s.axis = pad_axis;
    s.now  = pad_clock;
    if (r < 8) s.axis[$urandom_range(3)] = AXIS_BAD;
    return s;
  endfunction

  task automatic send_sample(input pad_sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push             <= 1'b1;
    in_func          <= s.func;
    in_keys          <= s.keys;
    in_stick_left_x  <= s.axis[0];
    in_stick_left_y  <= s.axis[1];
    in_stick_right_x <= s.axis[2];
    in_stick_right_y <= s.axis[3];
    in_now_ms        <= s.now;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_words(s);
  endtask

  task automatic wait_for_results();
    push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] dz, input logic [15:0] nt,
                            input logic [15:0] id, input logic [15:0] ri);
    write_reg(CFG_DEADZONE, dz);
    write_reg(CFG_NEUTRAL, nt);
    write_reg(CFG_INIT_DLY, id);
    write_reg(CFG_REP_INTVL, ri);
    cfg_we <= 1'b0;
    dead_zone    = dz[MAG_W-1:0];
    neutral_thr  = nt[MAG_W-1:0];
    init_delay   = id;
    rep_interval = ri;
  endtask

  task automatic test_button_edges();
    send_sample(pad_sample('0, 0, 0, 0, 0, 1000));
    send_sample(pad_sample('1, 32767, 32767, 32767, 32767, 1016));
    send_sample(pad_sample('1, -32767, -32767, -32767, -32767, 1032));
    send_sample(pad_sample('0, -32768, 0, 0, 0, 1040));
    send_sample(pad_sample('0, 0, -32768, 0, 0, 1044));
    send_sample(pad_sample('0, 0, 0, -32768, 0, 1048));
    send_sample(pad_sample('0, 0, 0, 0, -32768, 1052));
    send_sample(pad_sample(17'h1c0c0, 0, 0, 0, 0, 1064));
  endtask

  task automatic test_direction_repeat();
    send_sample(pad_sample((17'd1 << KEY_DPAD_RIGHT) | (17'd1 << KEY_DPAD_UP)
                           | (17'd1 << KEY_DPAD_DOWN), 0, 0, 0, 0, 2000));
    send_sample(pad_sample((17'd1 << KEY_DPAD_UP) | (17'd1 << KEY_DPAD_DOWN), 0, 0, 0, 0, 2016));
    send_sample(pad_sample(17'd1 << KEY_DPAD_DOWN, 0, 0, 0, 0, 2032));
    send_sample(pad_sample('0, -18000, 0, 0, 0, 2048));
    send_sample(pad_sample('0, 17999, -17999, 0, 0, 2064));
    send_sample(pad_sample('0, 0, 18000, 0, 0, 2080));
    send_sample(pad_sample('0, 0, 18000, 0, 0, 2479));
    send_sample(pad_sample('0, 0, 18000, 0, 0, 2480));
    send_sample(pad_sample('0, 0, 18000, 0, 0, 2579));
    send_sample(pad_sample('0, 0, 18000, 0, 0, 2580));
    // equal magnitudes pick the vertical, then the repeat spans the time wrap
    send_sample(pad_sample('0, 20000, -20000, 0, 0, 32'hffff_fff0));
    send_sample(pad_sample('0, 20000, -20000, 0, 0, 32'h0000_0180));
  endtask

  task automatic test_suppress();
    pad_sample_t s;
    s = pad_sample('1, 1234, -1234, 32767, -32767, 32'h0000_0200);
    s.func = FUNC_SUPPRESS;
    send_sample(s);
    send_sample(pad_sample(17'd1 << KEY_A, 0, 0, 0, 0, 32'h0000_0210));
    send_sample(pad_sample('0, 9830, 0, 0, 0, 32'h0000_0220));
    send_sample(pad_sample('0, 9829, -9829, 9829, -9829, 32'h0000_0230));
    send_sample(pad_sample(17'd1 << KEY_A, 0, 0, 0, 0, 32'h0000_0240));
    wait_for_results();
  endtask

  task automatic test_random_sweep();
    pad_clock = $urandom;
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin send_idle_pct = 7;  recv_idle_pct = 51; end
        1: begin send_idle_pct = 51; recv_idle_pct = 7;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (int k = 0; k < 3; k++) begin
        wait_for_results();
        case ((p * 3 + k) % 4)
          0: set_config(16'd0, 16'd0, 16'd0, 16'd0);
          1: set_config(16'h7fff, 16'h7fff, 16'hffff, 16'hffff);
          2: set_config(16'(DEADZONE_RST), 16'(NEUTRAL_RST), INIT_DLY_RST, REP_INTVL_RST);
          default: set_config(16'($urandom_range(0, 32767)), 16'($urandom_range(0, 32767)),
                              16'($urandom_range(0, 300)), 16'($urandom_range(0, 120)));
        endcase
        repeat (17) begin
          if ($urandom_range(49) == 0) wait_for_results();
          send_sample(random_sample());
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : word_check
    pad_word_t w;
    if (rst_n && pop && !empty) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: action_code %0d", out_action_code);
        fail_count++;
      end else begin
        w = expected_words.pop_front();
        check_field("action_code", w.code, out_action_code);
        check_field("is_repeat", w.rep, out_is_repeat);
        check_field("state_changed", w.chg, out_state_changed);
        check_field("rejected", w.rej, out_rejected);
        check_field("last", w.last, out_last);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    send_idle_pct = 7;
    recv_idle_pct = 51;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_button_edges();
    test_direction_repeat();
    test_suppress();
    test_random_sweep();
    wait_for_results();
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
